>>> design/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg: shared types, codes and channel maths for the pixel format converter
// Mask decoding into shift and width, and the per-channel extract and place
// functions used by the datapath.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int ENTRY_W           = 24;
    localparam int PIXEL_W           = 32;
    localparam int REG_IDX_W         = 3;

    // request codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_DIRECT  = 2'd1;
    localparam logic [1:0] REQ_PALETTE = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_SRC_RED   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_GREEN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SRC_BLUE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SRC_ALPHA = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DST_RED   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DST_GREEN = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DST_BLUE  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DST_ALPHA = 3'd7;

    localparam logic [PIXEL_W-1:0] RST_RED_MASK   = 32'h00ff_0000;
    localparam logic [PIXEL_W-1:0] RST_GREEN_MASK = 32'h0000_ff00;
    localparam logic [PIXEL_W-1:0] RST_BLUE_MASK  = 32'h0000_00ff;
    localparam logic [PIXEL_W-1:0] RST_ALPHA_MASK = 32'hff00_0000;

    typedef struct packed {
        logic [PIXEL_W-1:0] mask;
        logic [4:0]         shift;
        logic [3:0]         width;
    } chan_cfg_t;

    typedef struct packed {
        chan_cfg_t red;
        chan_cfg_t green;
        chan_cfg_t blue;
        chan_cfg_t alpha;
    } fmt_cfg_t;

    // trailing zero count, zero mask gives 0
    function automatic logic [4:0] mask_shift(input logic [PIXEL_W-1:0] m);
        logic [4:0] s;
        s = 5'd0;
        for (int i = PIXEL_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                s = 5'(i);
            end
        end
        return s;
    endfunction

    // length of the first run of ones, clamped to 8
    function automatic chan_cfg_t mask_decode(input logic [PIXEL_W-1:0] m);
        chan_cfg_t  c;
        logic [PIXEL_W-1:0] v;
        logic       stop;
        c.mask  = m;
        c.shift = mask_shift(m);
        c.width = 4'd0;
        v       = m >> c.shift;
        stop    = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!stop && v[i]) begin
                c.width = 4'(i + 1);
            end else begin
                stop = 1'b1;
            end
        end
        return c;
    endfunction

    // source field to 8-bit intermediate
    function automatic logic [7:0] take_channel(input logic [PIXEL_W-1:0] pix,
                                                input chan_cfg_t c);
        logic [PIXEL_W-1:0] v;
        logic [7:0]         low;
        logic [3:0]         sh;
        v   = (pix & c.mask) >> c.shift;
        low = v[7:0];
        sh  = 4'd8 - c.width;
        return 8'(low << sh);
    endfunction

    // 8-bit intermediate to destination field
    function automatic logic [PIXEL_W-1:0] place_channel(input logic [7:0] v8,
                                                         input chan_cfg_t c);
        logic [7:0] t;
        logic [3:0] sh;
        sh = 4'd8 - c.width;
        t  = v8 >> sh;
        return {24'd0, t} << c.shift;
    endfunction

endpackage

>>> design/pfc_ram.sv
// ----------------------------------------------------------------------------
// pfc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined until written.
// ----------------------------------------------------------------------------
module pfc_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/pfc_mask_regs.sv
// ----------------------------------------------------------------------------
// pfc_mask_regs: format mask registers
// Holds the eight channel masks, decoded to shift and width as they are written.
// ----------------------------------------------------------------------------
module pfc_mask_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [pfc_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [pfc_pkg::PIXEL_W-1:0]         cfg_data,
    output pfc_pkg::fmt_cfg_t                   src_fmt,
    output pfc_pkg::fmt_cfg_t                   dst_fmt
);
    import pfc_pkg::*;

    chan_cfg_t src_red_reg, src_green_reg, src_blue_reg, src_alpha_reg;
    chan_cfg_t dst_red_reg, dst_green_reg, dst_blue_reg, dst_alpha_reg;
    chan_cfg_t wr_cfg;

    // decode once on write so the pixel path sees plain shift and width
    assign wr_cfg = mask_decode(cfg_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_red_reg   <= mask_decode(RST_RED_MASK);
            src_green_reg <= mask_decode(RST_GREEN_MASK);
            src_blue_reg  <= mask_decode(RST_BLUE_MASK);
            src_alpha_reg <= mask_decode(RST_ALPHA_MASK);
            dst_red_reg   <= mask_decode(RST_RED_MASK);
            dst_green_reg <= mask_decode(RST_GREEN_MASK);
            dst_blue_reg  <= mask_decode(RST_BLUE_MASK);
            dst_alpha_reg <= mask_decode(RST_ALPHA_MASK);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SRC_RED:   src_red_reg   <= wr_cfg;
                REG_SRC_GREEN: src_green_reg <= wr_cfg;
                REG_SRC_BLUE:  src_blue_reg  <= wr_cfg;
                REG_SRC_ALPHA: src_alpha_reg <= wr_cfg;
                REG_DST_RED:   dst_red_reg   <= wr_cfg;
                REG_DST_GREEN: dst_green_reg <= wr_cfg;
                REG_DST_BLUE:  dst_blue_reg  <= wr_cfg;
                REG_DST_ALPHA: dst_alpha_reg <= wr_cfg;
                default: ;
            endcase
        end
    end

    assign src_fmt = '{red: src_red_reg, green: src_green_reg,
                       blue: src_blue_reg, alpha: src_alpha_reg};
    assign dst_fmt = '{red: dst_red_reg, green: dst_green_reg,
                       blue: dst_blue_reg, alpha: dst_alpha_reg};

endmodule

>>> design/pfc_convert.sv
// ----------------------------------------------------------------------------
// pfc_convert: pixel conversion datapath
// Extracts the four source channels (or the palette entry bytes) and packs
// them into the destination format.
// ----------------------------------------------------------------------------
module pfc_convert (
    input  pfc_pkg::fmt_cfg_t                 src_fmt,
    input  pfc_pkg::fmt_cfg_t                 dst_fmt,
    input  logic                              use_palette,
    input  logic [pfc_pkg::PIXEL_W-1:0]       pixel,
    input  logic [pfc_pkg::ENTRY_W-1:0]       entry,
    output logic [pfc_pkg::PIXEL_W-1:0]       out_pixel
);
    import pfc_pkg::*;

    logic [7:0] a8, r8, g8, b8;

    always_comb begin
        if (use_palette) begin
            a8 = 8'd0;
            r8 = entry[23:16];
            g8 = entry[15:8];
            b8 = entry[7:0];
        end else begin
            a8 = take_channel(pixel, src_fmt.alpha);
            r8 = take_channel(pixel, src_fmt.red);
            g8 = take_channel(pixel, src_fmt.green);
            b8 = take_channel(pixel, src_fmt.blue);
        end
    end

    assign out_pixel = place_channel(a8, dst_fmt.alpha) |
                       place_channel(r8, dst_fmt.red)   |
                       place_channel(g8, dst_fmt.green) |
                       place_channel(b8, dst_fmt.blue);

endmodule

>>> design/pixel_format_converter.sv
// ----------------------------------------------------------------------------
// pixel_format_converter: mask-described RGBA pixel format converter
// Input words on s_* carry a request: a palette write (no result), a direct
// pixel conversion, or a palette index conversion. Each conversion gives one
// result word on m_*. Source and destination formats are set by eight mask
// registers written over cfg_*, which is always ready and must only be used
// while no conversion is in flight.
// An accepted word passes one input stage (palette read lands here) and one
// result register, which drives m_valid, before it can be taken on m_*.
// Throughput is one word per clock while the receiver does not stall, set by
// the single palette read port and the result register.
// When the receiver stalls, the input stage still takes one more word, then
// s_ready drops until the result register drains; nothing is dropped.
// Reset empties both stages and restores 8:8:8:8 ARGB masks on both sides;
// palette contents are undefined until written, and need no clearing pass.
// ----------------------------------------------------------------------------
module pixel_format_converter #(
    parameter int PALETTE_DEPTH = pfc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic [pfc_pkg::PIXEL_W-1:0]       s_pixel,
    input  logic [7:0]                        s_palette_index,
    input  logic [pfc_pkg::ENTRY_W-1:0]       s_entry_color,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pfc_pkg::PIXEL_W-1:0]       m_out_pixel,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfc_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [pfc_pkg::PIXEL_W-1:0]       cfg_data
);
    import pfc_pkg::*;

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    fmt_cfg_t           src_fmt, dst_fmt;
    logic               s_fire, is_conv, in_range;
    logic               b_ready;
    logic [IDX_W-1:0]   pal_addr;
    logic [ENTRY_W-1:0] pal_rd_data, entry;
    logic [PIXEL_W-1:0] conv_pixel;

    logic               a_valid_reg, a_palette_reg, a_oob_reg;
    logic [PIXEL_W-1:0] a_pixel_reg;
    logic               m_valid_reg;
    logic [PIXEL_W-1:0] m_pixel_reg;

    assign cfg_ready = 1'b1;

    pfc_mask_regs u_mask_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_fmt   (src_fmt),
        .dst_fmt   (dst_fmt)
    );

    assign b_ready = !m_valid_reg || m_ready;
    assign s_ready = !a_valid_reg || b_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        is_conv = s_req_type inside {REQ_DIRECT, REQ_PALETTE};
    end

    assign in_range = {1'b0, s_palette_index} < 9'(PALETTE_DEPTH);
    assign pal_addr = IDX_W'(s_palette_index);

    pfc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (s_fire && (s_req_type == REQ_WRITE) && in_range),
        .wr_addr (pal_addr),
        .wr_data (s_entry_color),
        .rd_en   (s_fire && (s_req_type == REQ_PALETTE) && in_range),
        .rd_addr (pal_addr),
        .rd_data (pal_rd_data)
    );

    // index beyond the palette reads as black
    assign entry = a_oob_reg ? '0 : pal_rd_data;

    pfc_convert u_convert (
        .src_fmt     (src_fmt),
        .dst_fmt     (dst_fmt),
        .use_palette (a_palette_reg),
        .pixel       (a_pixel_reg),
        .entry       (entry),
        .out_pixel   (conv_pixel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_fire && is_conv;
            end
            if (b_ready) begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && is_conv) begin
            a_palette_reg <= (s_req_type == REQ_PALETTE);
            a_oob_reg     <= !in_range;
            a_pixel_reg   <= s_pixel;
        end
        if (b_ready && a_valid_reg) begin
            m_pixel_reg <= conv_pixel;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_pixel = m_pixel_reg;

endmodule
